// ===== src/ted_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Train event detector package
// Request and response types, mode codes, register indexes and fixed limits.
// ----------------------------------------------------------------------------
package ted_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int TIME_WIDTH  = 32;
   localparam int CODE_WIDTH  = 10;
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = 16;
   // power of two and at least 2: the queue pointers wrap on their own width
   localparam int OUT_DEPTH   = 4;

   localparam logic [COUNT_WIDTH-1:0] JUMP_LIMIT      = COUNT_WIDTH'(100);
   localparam logic [TIME_WIDTH-1:0]  CONFIRM_TIMEOUT = TIME_WIDTH'(70);
   localparam logic [CODE_WIDTH-1:0]  DEP_ID_BASE     = CODE_WIDTH'(50);
   localparam logic [CODE_WIDTH-1:0]  ARR_ID_BASE     = CODE_WIDTH'(60);
   localparam logic [COUNT_WIDTH-1:0] THRESHOLD_RESET = COUNT_WIDTH'(4);
   localparam logic [15:0]            QUIET_RESET     = 16'd15;

   localparam logic KIND_DEPARTURE = 1'b0;
   localparam logic KIND_ARRIVAL   = 1'b1;

   typedef enum logic [2:0] {
      MODE_WAITING  = 3'b001,
      MODE_PENDING  = 3'b010,
      MODE_TRAILING = 3'b100
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEPARTURE_CODE    = 4'd0,
      CSR_ARRIVAL_CODE      = 4'd1,
      CSR_CONFIRM_ENABLED   = 4'd2,
      CSR_INITIAL_DEPARTURE = 4'd3,
      CSR_INITIAL_ARRIVAL   = 4'd4,
      CSR_INITIAL_CONFIRM   = 4'd5,
      CSR_COUNT_THRESHOLD   = 4'd6,
      CSR_QUIET_SECONDS     = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0] departure_sample;
      logic [COUNT_WIDTH-1:0] arrival_sample;
      logic [COUNT_WIDTH-1:0] confirm_sample;
      logic [TIME_WIDTH-1:0]  now_seconds;
   } req_type;

   typedef struct packed {
      logic [CODE_WIDTH-1:0] event_id;
      logic                  event_kind;
      logic [TIME_WIDTH-1:0] event_start;
      logic                  was_confirmed;
      logic                  last_of_run;
   } rsp_type;

endpackage

// ===== src/train_event_detector_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Train event detector core
// Tracks wrapping departure, arrival and confirm counters and reports
// departure and arrival events, directly or after confirmation.
// ----------------------------------------------------------------------------
// A request is taken into an input register on the edge it is accepted and is
// worked off in one pass once the queue has at least two free places, which
// updates the detector state and writes zero, one or two responses into an
// OUT_DEPTH-entry response queue; a response shows on rsp_valid only after
// its request has been registered and worked off. One request is taken per cycle
// while the queue has at least two free places; the queue drains one response
// per cycle while rsp_stall is low, so the sustained rate is one request per
// cycle as long as requests average at most one response each. Configuration
// writes are taken whenever the input register is empty.
module train_event_detector_core
   import ted_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_payload,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int PTR_W = $clog2(OUT_DEPTH);
   localparam int CNT_W = $clog2(OUT_DEPTH + 1);
   localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(OUT_DEPTH - 2);

   // configuration
   logic [CODE_WIDTH-1:0]  dep_code_ff, dep_code_in;
   logic [CODE_WIDTH-1:0]  arr_code_ff, arr_code_in;
   logic                   confirm_en_ff, confirm_en_in;
   logic [COUNT_WIDTH-1:0] threshold_ff, threshold_in;
   logic [15:0]            quiet_ff, quiet_in;

   // detector state
   mode_type               mode_ff, mode_in;
   logic [COUNT_WIDTH-1:0] dep_epoch_ff, dep_epoch_in;
   logic [COUNT_WIDTH-1:0] dep_prev_ff, dep_prev_in;
   logic [COUNT_WIDTH-1:0] arr_epoch_ff, arr_epoch_in;
   logic [COUNT_WIDTH-1:0] arr_prev_ff, arr_prev_in;
   logic [COUNT_WIDTH-1:0] con_epoch_ff, con_epoch_in;
   logic [COUNT_WIDTH-1:0] con_prev_ff, con_prev_in;
   logic                   cur_kind_ff, cur_kind_in;
   logic [TIME_WIDTH-1:0]  start_stamp_ff, start_stamp_in;
   logic [TIME_WIDTH-1:0]  change_stamp_ff, change_stamp_in;
   logic                   awaiting_ff, awaiting_in;
   logic                   held_kind_ff, held_kind_in;
   logic [TIME_WIDTH-1:0]  held_start_ff, held_start_in;
   logic [TIME_WIDTH-1:0]  window_start_ff, window_start_in;

   // input register
   logic                   in_valid_ff, in_valid_in;
   req_type                in_data_ff;

   // response queue
   rsp_type                queue_ff [OUT_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;

   logic                   req_accept;
   logic                   csr_write;
   logic                   process_go;
   logic                   pop;

   logic [COUNT_WIDTH-1:0] dep_total, arr_total, con_total;
   logic [COUNT_WIDTH-1:0] dep_delta, arr_delta;
   logic                   changed;
   logic                   jump;
   logic [TIME_WIDTH-1:0]  change_stamp_new;
   logic                   quiet_gap;

   logic                   hold_now;
   logic                   direct_emit, confirm_emit;
   rsp_type                direct_rsp, confirm_rsp;
   rsp_type                first_rsp, second_rsp;
   logic [1:0]             push_count;

   function automatic logic [CODE_WIDTH-1:0] event_code(
      input logic                  kind,
      input logic [CODE_WIDTH-1:0] dep_code,
      input logic [CODE_WIDTH-1:0] arr_code
   );
      return (kind == KIND_ARRIVAL) ? ARR_ID_BASE + arr_code : DEP_ID_BASE + dep_code;
   endfunction

   // handshakes
   assign process_go = in_valid_ff && (count_ff <= ROOM_LIMIT);
   assign req_stall  = in_valid_ff && !process_go;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = !in_valid_ff;
   assign csr_write  = csr_valid && csr_ready;
   assign rsp_valid  = (count_ff != '0);
   assign pop        = rsp_valid && !rsp_stall;
   assign rsp_payload = queue_ff[rd_ptr_ff];

   // wrap-aware totals and deltas against the old epochs and previous samples
   assign dep_total = in_data_ff.departure_sample - dep_epoch_ff;
   assign arr_total = in_data_ff.arrival_sample - arr_epoch_ff;
   assign con_total = in_data_ff.confirm_sample - con_epoch_ff;
   assign dep_delta = in_data_ff.departure_sample - dep_prev_ff;
   assign arr_delta = in_data_ff.arrival_sample - arr_prev_ff;

   assign changed          = (dep_delta != '0) || (arr_delta != '0);
   assign jump             = (dep_delta > JUMP_LIMIT) || (arr_delta > JUMP_LIMIT);
   assign change_stamp_new = changed ? in_data_ff.now_seconds : change_stamp_ff;
   assign quiet_gap = (in_data_ff.now_seconds - change_stamp_new) > TIME_WIDTH'(quiet_ff);

   always_comb begin
      dep_code_in     = dep_code_ff;
      arr_code_in     = arr_code_ff;
      confirm_en_in   = confirm_en_ff;
      threshold_in    = threshold_ff;
      quiet_in        = quiet_ff;
      mode_in         = mode_ff;
      dep_epoch_in    = dep_epoch_ff;
      dep_prev_in     = dep_prev_ff;
      arr_epoch_in    = arr_epoch_ff;
      arr_prev_in     = arr_prev_ff;
      con_epoch_in    = con_epoch_ff;
      con_prev_in     = con_prev_ff;
      cur_kind_in     = cur_kind_ff;
      start_stamp_in  = start_stamp_ff;
      change_stamp_in = change_stamp_ff;
      awaiting_in     = awaiting_ff;
      held_kind_in    = held_kind_ff;
      held_start_in   = held_start_ff;
      window_start_in = window_start_ff;
      hold_now        = 1'b0;
      direct_emit     = 1'b0;
      confirm_emit    = 1'b0;

      if (process_go) begin
         change_stamp_in = change_stamp_new;
         if (jump) begin
            dep_epoch_in = in_data_ff.departure_sample;
            arr_epoch_in = in_data_ff.arrival_sample;
         end

         unique case (mode_ff)
            MODE_WAITING: begin
               if (dep_total != '0) begin
                  cur_kind_in    = KIND_DEPARTURE;
                  mode_in        = MODE_PENDING;
                  start_stamp_in = in_data_ff.now_seconds;
               end else if (arr_total != '0) begin
                  cur_kind_in    = KIND_ARRIVAL;
                  mode_in        = MODE_PENDING;
                  start_stamp_in = in_data_ff.now_seconds;
               end
            end
            MODE_PENDING: begin
               if ((dep_total > threshold_ff) && (arr_total > threshold_ff)) begin
                  mode_in = MODE_TRAILING;
                  if (!confirm_en_ff || (cur_kind_ff == KIND_ARRIVAL)) begin
                     direct_emit = 1'b1;
                  end else begin
                     // hold the departure; confirm count restarts from here
                     hold_now        = 1'b1;
                     held_kind_in    = cur_kind_ff;
                     held_start_in   = start_stamp_ff;
                     window_start_in = in_data_ff.now_seconds;
                     con_epoch_in    = in_data_ff.confirm_sample;
                     awaiting_in     = 1'b1;
                  end
               end else if (quiet_gap) begin
                  mode_in = MODE_WAITING;
               end
            end
            default: begin
               if (quiet_gap) begin
                  mode_in      = MODE_WAITING;
                  dep_epoch_in = dep_prev_ff;
                  arr_epoch_in = arr_prev_ff;
               end
            end
         endcase

         // a hold taken in this pass sees a zero confirm total and no timeout
         if (awaiting_ff && !hold_now) begin
            if (con_total > threshold_ff) begin
               confirm_emit = 1'b1;
               awaiting_in  = 1'b0;
            end else if ((in_data_ff.now_seconds - window_start_ff) > CONFIRM_TIMEOUT) begin
               awaiting_in = 1'b0;
            end
         end

         dep_prev_in = in_data_ff.departure_sample;
         arr_prev_in = in_data_ff.arrival_sample;
         con_prev_in = in_data_ff.confirm_sample;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_DEPARTURE_CODE: begin
               dep_code_in = csr_data[CODE_WIDTH-1:0];
               mode_in     = MODE_WAITING;
            end
            CSR_ARRIVAL_CODE: begin
               arr_code_in = csr_data[CODE_WIDTH-1:0];
               mode_in     = MODE_WAITING;
            end
            CSR_CONFIRM_ENABLED: begin
               confirm_en_in = csr_data[0];
               mode_in       = MODE_WAITING;
            end
            CSR_INITIAL_DEPARTURE: begin
               dep_epoch_in = csr_data[COUNT_WIDTH-1:0];
               dep_prev_in  = csr_data[COUNT_WIDTH-1:0];
               mode_in      = MODE_WAITING;
               awaiting_in  = 1'b0;
            end
            CSR_INITIAL_ARRIVAL: begin
               arr_epoch_in = csr_data[COUNT_WIDTH-1:0];
               arr_prev_in  = csr_data[COUNT_WIDTH-1:0];
               mode_in      = MODE_WAITING;
               awaiting_in  = 1'b0;
            end
            CSR_INITIAL_CONFIRM: begin
               con_epoch_in = csr_data[COUNT_WIDTH-1:0];
               con_prev_in  = csr_data[COUNT_WIDTH-1:0];
               mode_in      = MODE_WAITING;
               awaiting_in  = 1'b0;
            end
            CSR_COUNT_THRESHOLD: threshold_in = csr_data[COUNT_WIDTH-1:0];
            CSR_QUIET_SECONDS:   quiet_in     = csr_data;
            default: ;
         endcase
      end
   end

   // responses of this pass: a direct event goes ahead of a confirmed one
   always_comb begin
      direct_rsp.event_id      = event_code(cur_kind_ff, dep_code_ff, arr_code_ff);
      direct_rsp.event_kind    = cur_kind_ff;
      direct_rsp.event_start   = start_stamp_ff;
      direct_rsp.was_confirmed = 1'b0;
      direct_rsp.last_of_run   = !confirm_emit;

      confirm_rsp.event_id      = event_code(held_kind_ff, dep_code_ff, arr_code_ff);
      confirm_rsp.event_kind    = held_kind_ff;
      confirm_rsp.event_start   = held_start_ff;
      confirm_rsp.was_confirmed = 1'b1;
      confirm_rsp.last_of_run   = 1'b1;

      first_rsp  = direct_emit ? direct_rsp : confirm_rsp;
      second_rsp = confirm_rsp;
      push_count = 2'(direct_emit) + 2'(confirm_emit);
   end

   always_comb begin
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (process_go) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_count);
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push_count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dep_code_ff     <= '0;
         arr_code_ff     <= '0;
         confirm_en_ff   <= 1'b0;
         threshold_ff    <= THRESHOLD_RESET;
         quiet_ff        <= QUIET_RESET;
         mode_ff         <= MODE_WAITING;
         dep_epoch_ff    <= '0;
         dep_prev_ff     <= '0;
         arr_epoch_ff    <= '0;
         arr_prev_ff     <= '0;
         con_epoch_ff    <= '0;
         con_prev_ff     <= '0;
         cur_kind_ff     <= KIND_DEPARTURE;
         start_stamp_ff  <= '0;
         change_stamp_ff <= '0;
         awaiting_ff     <= 1'b0;
         held_kind_ff    <= KIND_DEPARTURE;
         held_start_ff   <= '0;
         window_start_ff <= '0;
         in_valid_ff     <= 1'b0;
         wr_ptr_ff       <= '0;
         rd_ptr_ff       <= '0;
         count_ff        <= '0;
      end else begin
         dep_code_ff     <= dep_code_in;
         arr_code_ff     <= arr_code_in;
         confirm_en_ff   <= confirm_en_in;
         threshold_ff    <= threshold_in;
         quiet_ff        <= quiet_in;
         mode_ff         <= mode_in;
         dep_epoch_ff    <= dep_epoch_in;
         dep_prev_ff     <= dep_prev_in;
         arr_epoch_ff    <= arr_epoch_in;
         arr_prev_ff     <= arr_prev_in;
         con_epoch_ff    <= con_epoch_in;
         con_prev_ff     <= con_prev_in;
         cur_kind_ff     <= cur_kind_in;
         start_stamp_ff  <= start_stamp_in;
         change_stamp_ff <= change_stamp_in;
         awaiting_ff     <= awaiting_in;
         held_kind_ff    <= held_kind_in;
         held_start_ff   <= held_start_in;
         window_start_ff <= window_start_in;
         in_valid_ff     <= in_valid_in;
         wr_ptr_ff       <= wr_ptr_in;
         rd_ptr_ff       <= rd_ptr_in;
         count_ff        <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_payload;
      end
      if (push_count != 2'd0) begin
         queue_ff[wr_ptr_ff] <= first_rsp;
      end
      if (push_count == 2'd2) begin
         queue_ff[wr_ptr_ff + PTR_W'(1)] <= second_rsp;
      end
   end

endmodule

// ===== verif/ted_event_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Train event detector checker
// Watches the request, response and register channels of the detector and
// keeps its own model of the detector state. Each accepted request yields
// the events it must cause. Each accepted response is compared field by
// field with the oldest of those events, and every difference is counted.
// ----------------------------------------------------------------------------
module ted_event_checker
   import ted_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_type               req_payload,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_type               rsp_payload,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    failures,
   output int                    outstanding
);

   // register copies
   logic [CODE_WIDTH-1:0]  dep_code, arr_code;
   logic                   confirm_on;
   logic [COUNT_WIDTH-1:0] threshold;
   logic [15:0]            quiet_limit;

   // detector state
   mode_type               mode;
   logic [COUNT_WIDTH-1:0] dep_epoch, dep_prev, arr_epoch, arr_prev, con_epoch, con_prev;
   logic                   cur_kind, held_kind, awaiting;
   logic [TIME_WIDTH-1:0]  start_stamp, last_change, held_start, window_start;

   rsp_type expected_events[$];

   task automatic clear_state();
      dep_code     = '0;
      arr_code     = '0;
      confirm_on   = 1'b0;
      threshold    = THRESHOLD_RESET;
      quiet_limit  = QUIET_RESET;
      mode         = MODE_WAITING;
      dep_epoch    = '0;
      dep_prev     = '0;
      arr_epoch    = '0;
      arr_prev     = '0;
      con_epoch    = '0;
      con_prev     = '0;
      cur_kind     = KIND_DEPARTURE;
      held_kind    = KIND_DEPARTURE;
      awaiting     = 1'b0;
      start_stamp  = '0;
      last_change  = '0;
      held_start   = '0;
      window_start = '0;
   endtask

   task automatic apply_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      case (csr_index_type'(idx))
         CSR_DEPARTURE_CODE: begin
            dep_code = data[CODE_WIDTH-1:0];
            mode     = MODE_WAITING;
         end
         CSR_ARRIVAL_CODE: begin
            arr_code = data[CODE_WIDTH-1:0];
            mode     = MODE_WAITING;
         end
         CSR_CONFIRM_ENABLED: begin
            confirm_on = data[0];
            mode       = MODE_WAITING;
         end
         CSR_INITIAL_DEPARTURE: begin
            dep_epoch = data;
            dep_prev  = data;
            mode      = MODE_WAITING;
            awaiting  = 1'b0;
         end
         CSR_INITIAL_ARRIVAL: begin
            arr_epoch = data;
            arr_prev  = data;
            mode      = MODE_WAITING;
            awaiting  = 1'b0;
         end
         CSR_INITIAL_CONFIRM: begin
            con_epoch = data;
            con_prev  = data;
            mode      = MODE_WAITING;
            awaiting  = 1'b0;
         end
         CSR_COUNT_THRESHOLD: threshold = data;
         CSR_QUIET_SECONDS: quiet_limit = data;
         default: ;
      endcase
   endtask

   function automatic rsp_type make_event(logic kind, logic [TIME_WIDTH-1:0] start,
                                          logic confirmed);
      rsp_type ev;
      ev.event_id      = (kind == KIND_ARRIVAL) ? ARR_ID_BASE + arr_code
                                                : DEP_ID_BASE + dep_code;
      ev.event_kind    = kind;
      ev.event_start   = start;
      ev.was_confirmed = confirmed;
      ev.last_of_run   = 1'b0;
      return ev;
   endfunction

   task automatic predict_events(input req_type r);
      logic [COUNT_WIDTH-1:0] dep_total, arr_total, con_total, dep_delta, arr_delta;
      logic [TIME_WIDTH-1:0]  now;
      rsp_type                found [2];
      int                     n;
      n         = 0;
      now       = r.now_seconds;
      dep_total = r.departure_sample - dep_epoch;
      arr_total = r.arrival_sample - arr_epoch;
      con_total = r.confirm_sample - con_epoch;
      dep_delta = r.departure_sample - dep_prev;
      arr_delta = r.arrival_sample - arr_prev;

      if (dep_delta != 0 || arr_delta != 0) begin
         last_change = now;
      end
      // re-base on a jump, but keep this request's totals
      if (dep_delta > JUMP_LIMIT || arr_delta > JUMP_LIMIT) begin
         dep_epoch = r.departure_sample;
         arr_epoch = r.arrival_sample;
      end

      case (mode)
         MODE_WAITING: begin
            if (dep_total != 0) begin
               cur_kind    = KIND_DEPARTURE;
               mode        = MODE_PENDING;
               start_stamp = now;
            end else if (arr_total != 0) begin
               cur_kind    = KIND_ARRIVAL;
               mode        = MODE_PENDING;
               start_stamp = now;
            end
         end
         MODE_PENDING: begin
            if (dep_total > threshold && arr_total > threshold) begin
               mode = MODE_TRAILING;
               if (!confirm_on || cur_kind == KIND_ARRIVAL) begin
                  found[n] = make_event(cur_kind, start_stamp, 1'b0);
                  n++;
               end else begin
                  // hold the departure; confirm counting restarts here
                  held_kind    = cur_kind;
                  held_start   = start_stamp;
                  window_start = now;
                  con_epoch    = r.confirm_sample;
                  con_total    = '0;
                  awaiting     = 1'b1;
               end
            end else if (TIME_WIDTH'(now - last_change) > quiet_limit) begin
               mode = MODE_WAITING;
            end
         end
         default: begin
            if (TIME_WIDTH'(now - last_change) > quiet_limit) begin
               mode      = MODE_WAITING;
               dep_epoch = dep_prev;
               arr_epoch = arr_prev;
            end
         end
      endcase

      if (awaiting) begin
         if (con_total > threshold) begin
            found[n] = make_event(held_kind, held_start, 1'b1);
            n++;
            awaiting = 1'b0;
         end else if (TIME_WIDTH'(now - window_start) > CONFIRM_TIMEOUT) begin
            awaiting = 1'b0;
         end
      end

      dep_prev = r.departure_sample;
      arr_prev = r.arrival_sample;
      con_prev = r.confirm_sample;

      for (int i = 0; i < n; i++) begin
         if (i == n - 1) begin
            found[i].last_of_run = 1'b1;
         end
         expected_events.push_back(found[i]);
      end
   endtask

   task automatic check_event(input rsp_type got);
      rsp_type want;
      if (expected_events.size() == 0) begin
         $error("response with no request waiting: id %0d start %0d",
                got.event_id, got.event_start);
         failures++;
      end else begin
         want = expected_events.pop_front();
         if (got.event_id != want.event_id) begin
            $error("event_id: expected %0d, got %0d", want.event_id, got.event_id);
            failures++;
         end
         if (got.event_kind != want.event_kind) begin
            $error("event_kind: expected %0d, got %0d", want.event_kind, got.event_kind);
            failures++;
         end
         if (got.event_start != want.event_start) begin
            $error("event_start: expected %0d, got %0d", want.event_start, got.event_start);
            failures++;
         end
         if (got.was_confirmed != want.was_confirmed) begin
            $error("was_confirmed: expected %0d, got %0d",
                   want.was_confirmed, got.was_confirmed);
            failures++;
         end
         if (got.last_of_run != want.last_of_run) begin
            $error("last_of_run: expected %0d, got %0d", want.last_of_run, got.last_of_run);
            failures++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_state();
         expected_events.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            apply_register(csr_index, csr_data);
         end
         if (req_valid && !req_stall) begin
            predict_events(req_payload);
         end
         if (rsp_valid && !rsp_stall) begin
            check_event(rsp_payload);
         end
      end
      outstanding = expected_events.size();
   end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Train event detector testbench
// Drives sensor samples shaped as passing trains (one side counting first,
// then both, confirm counts and quiet gaps), mixed with counter jumps and
// random noise, across several register settings. Both channels idle and
// stall at random; the checker beside the detector predicts every event.
// ----------------------------------------------------------------------------
module tb;
   import ted_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_INDEX = 4'd11;
   localparam int STUCK_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 6;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_payload;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   int failures;
   int outstanding;
   int sent = 0;
   int stuck_cycles = 0;
   logic calm;

   logic [COUNT_WIDTH-1:0] dep_cnt = '0, arr_cnt = '0, con_cnt = '0;
   logic [TIME_WIDTH-1:0]  now_s = '0;
   logic [15:0]            cfg_threshold = THRESHOLD_RESET;
   logic [15:0]            cfg_quiet = QUIET_RESET;

   // no random idling on either side over this stretch of requests
   assign calm = (sent >= 1200 && sent < 1450);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   train_event_detector_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   ted_event_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .failures    (failures),
      .outstanding (outstanding)
   );

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // response side: random stall, one long hold-off to fill the detector
   initial begin : rsp_side
      int   hold_left;
      logic hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (!hold_done && sent >= 600) begin
            hold_done = 1'b1;
            hold_left = 250;
            rsp_stall <= 1'b1;
         end else if (calm) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < 22);
         end
      end
   end

   task automatic send_req(input req_type p);
      while (!calm && $urandom_range(99) < 22) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (req_stall);
      sent++;
      @(negedge clock);
   endtask

   task automatic step(input int dd, input int da, input int dc, input int dt);
      req_type p;
      dep_cnt += COUNT_WIDTH'(dd);
      arr_cnt += COUNT_WIDTH'(da);
      con_cnt += COUNT_WIDTH'(dc);
      now_s   += TIME_WIDTH'(dt);
      p.departure_sample = dep_cnt;
      p.arrival_sample   = arr_cnt;
      p.confirm_sample   = con_cnt;
      p.now_seconds      = now_s;
      send_req(p);
   endtask

   // leave csr_valid high between back-to-back writes; the caller drops it
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic configure(input logic [15:0] dcode, input logic [15:0] acode,
                            input logic [15:0] conf, input logic [15:0] idep,
                            input logic [15:0] iarr, input logic [15:0] icon,
                            input logic [15:0] thr, input logic [15:0] qt);
      write_csr(CSR_DEPARTURE_CODE, dcode);
      write_csr(CSR_ARRIVAL_CODE, acode);
      write_csr(CSR_CONFIRM_ENABLED, conf);
      write_csr(CSR_INITIAL_DEPARTURE, idep);
      write_csr(CSR_INITIAL_ARRIVAL, iarr);
      write_csr(CSR_INITIAL_CONFIRM, icon);
      write_csr(CSR_COUNT_THRESHOLD, thr);
      write_csr(CSR_QUIET_SECONDS, qt);
      csr_valid <= 1'b0;
      cfg_threshold = thr;
      cfg_quiet     = qt;
      dep_cnt       = idep;
      arr_cnt       = iarr;
      con_cnt       = icon;
   endtask

   // drop valid, wait for every response, then let the pipeline empty
   task automatic settle();
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic send_noise();
      case ($urandom_range(3))
         0: begin
            dep_cnt = COUNT_WIDTH'($urandom);
            arr_cnt = COUNT_WIDTH'($urandom);
            con_cnt = COUNT_WIDTH'($urandom);
            now_s   = $urandom;
         end
         1: dep_cnt += COUNT_WIDTH'($urandom_range(101, 3000));
         2: arr_cnt += COUNT_WIDTH'($urandom_range(101, 3000));
         default: now_s += $urandom_range(16, 2000);
      endcase
      step(0, 0, 0, 0);
   endtask

   task automatic run_train();
      int   inc, len, lead, tail, dt, pick;
      logic lead_arrival;
      lead_arrival = ($urandom_range(1) == 1);
      inc  = (cfg_threshold > 20) ? 30 : 2;
      len  = (cfg_threshold > 20) ? $urandom_range(8, 24)
                                  : cfg_threshold + $urandom_range(2, 8);
      lead = $urandom_range(1, 3);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(99) < 6) begin
            send_noise();
         end else if (i < lead) begin
            step(lead_arrival ? 0 : $urandom_range(1, inc),
                 lead_arrival ? $urandom_range(1, inc) : 0,
                 0, $urandom_range(0, 3));
         end else begin
            step(($urandom_range(99) < 80) ? $urandom_range(0, inc) : 0,
                 ($urandom_range(99) < 80) ? $urandom_range(0, inc) : 0,
                 ($urandom_range(99) < 30) ? $urandom_range(0, inc) : 0,
                 $urandom_range(0, 3));
         end
      end
      // confirm sensor counting after the train has passed
      tail = $urandom_range(0, 4);
      for (int i = 0; i < tail; i++) begin
         step(0, 0, $urandom_range(0, inc + 2), $urandom_range(0, 3));
      end
      pick = $urandom_range(99);
      if (pick < 55) begin
         dt = cfg_quiet + $urandom_range(1, 20);
      end else if (pick < 80) begin
         dt = $urandom_range(60, 80);
      end else begin
         dt = $urandom_range(0, 12);
      end
      step(0, 0, 0, dt);
   endtask

   task automatic run_phase(input int count);
      int stop;
      stop = sent + count;
      while (sent < stop) run_train();
      settle();
   endtask

   initial begin
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: all-zero request, then all-ones request
      step(0, 0, 0, 0);
      dep_cnt = '1;
      arr_cnt = '1;
      con_cnt = '1;
      now_s   = '1;
      step(0, 0, 0, 0);
      settle();

      // code 1023 wraps the departure id; unused index must be ignored
      write_csr(CSR_SPARE_INDEX, 16'hFFFF);
      configure(16'hFFFF, 16'd900, 16'd1, 16'd65533, 16'd65535, 16'd65530,
                16'd2, 16'd10);
      now_s = 32'hFFFF_FFF0;
      step(0, 0, 0, 0);
      step(1, 0, 0, 1);      // departure starts
      step(2, 2, 0, 2);      // both counters wrap
      step(1, 1, 0, 3);      // departure held
      step(0, 0, 3, 1);      // confirmed
      step(0, 0, 0, 12);     // quiet gap ends the trailing stretch
      step(0, 1, 0, 1);      // arrival starts
      step(0, 0, 0, 11);     // quiet gap while pending
      step(3, 3, 0, 1);
      step(1, 1, 0, 1);      // departure held
      step(1, 0, 0, 71);     // confirm window runs out
      step(0, 0, 3, 12);     // late confirm, nothing held
      step(1, 0, 0, 1);
      step(3, 3, 0, 1);      // departure held
      step(0, 0, 0, 12);
      step(0, 1, 0, 1);
      step(3, 3, 3, 1);      // arrival sent and held departure confirmed together
      step(0, 0, 0, 12);
      step(250, 0, 0, 1);    // jump re-bases the epochs
      step(0, 0, 0, 12);
      settle();

      configure(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd4, 16'd15);
      run_phase(300);
      configure(16'hFFFF, 16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
      run_phase(250);
      configure(16'($urandom_range(900)), 16'($urandom_range(900)), 16'd1,
                16'($urandom), 16'($urandom), 16'($urandom), 16'd3, 16'd20);
      run_phase(300);
      configure(16'($urandom_range(900)), 16'($urandom_range(900)), 16'd0,
                16'($urandom), 16'($urandom), 16'($urandom), 16'd7, 16'hFFFF);
      run_phase(80);
      configure(16'($urandom_range(900)), 16'($urandom_range(900)), 16'd1,
                16'($urandom), 16'($urandom), 16'($urandom), 16'd200, 16'd30);
      run_phase(250);
      configure(16'd900, 16'd900, 16'd1, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd10);
      run_phase(80);
      configure(16'($urandom), 16'($urandom), 16'd1, 16'($urandom), 16'($urandom),
                16'($urandom), 16'd1, 16'd5);
      run_phase(350);
      configure(16'($urandom_range(900)), 16'($urandom_range(900)), 16'hFFFE,
                16'($urandom), 16'($urandom), 16'($urandom), 16'd12, 16'd40);
      run_phase(300);

      if (failures == 0 && outstanding == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
